@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the checker modules of the lens warp engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define RLW_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rlw assertion failed");

// Antecedent in one cycle implies consequent in the next, outside reset.
`define RLW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rlw next-cycle assertion failed");

`endif

@@ hw/rtl/rlw_pkg.sv @@
// Types and constants shared by the radial lens warp engine modules.
package rlw_pkg;

    // Field and datapath widths
    localparam int PIX_W   = 8;
    localparam int COORD_W = 6;
    localparam int SIZE_W  = 7;
    localparam int ABS_W   = 7;
    localparam int FRAC_W  = 16;
    localparam int RATIO_W = FRAC_W + 1;
    localparam int SCALE_W = 17;
    localparam int MAG_W   = 7;

    // Q16 warp constants: 0.8, 0.2 and 1.8
    localparam logic [FRAC_W-1:0]  Q_EIGHT_TENTHS    = 16'd52429;
    localparam logic [SCALE_W-1:0] Q_TWO_TENTHS      = 17'd13107;
    localparam logic [SCALE_W-1:0] Q_EIGHTEEN_TENTHS = 17'd117965;

    // Opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Lens modes
    localparam logic MODE_FISHEYE = 1'b0;
    localparam logic MODE_BARREL  = 1'b1;

    // Register indexes (word address)
    localparam logic [1:0] REG_COLS = 2'd0;
    localparam logic [1:0] REG_ROWS = 2'd1;
    localparam logic [1:0] REG_MODE = 2'd2;

    typedef struct packed {
        logic               opcode;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic [PIX_W-1:0]   red_in;
        logic [PIX_W-1:0]   green_in;
        logic [PIX_W-1:0]   blue_in;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0]   red_out;
        logic [PIX_W-1:0]   green_out;
        logic [PIX_W-1:0]   blue_out;
        logic [COORD_W-1:0] source_column;
        logic [COORD_W-1:0] source_row;
    } out_item_t;

    // Effective (clamped) configuration
    typedef struct packed {
        logic [SIZE_W-1:0] cols;
        logic [SIZE_W-1:0] rows;
        logic              mode;
    } cfg_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic write;
        logic div_start;
        logic div_sel_y;
        logic load_rx;
        logic load_ry;
        logic calc_term;
        logic calc_scale;
        logic calc_mag;
        logic calc_coord;
        logic fetch;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_read;
        logic out_of_image;
        logic pass_through;
        logic div_done;
    } dp_status_t;

endpackage

@@ hw/rtl/rlw_div.sv @@
// Iterative divider producing the Q16 ratio of an offset to an image extent.
module rlw_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rlw_pkg::ABS_W-1:0]   dividend,
    input  logic [rlw_pkg::SIZE_W-1:0]  divisor,
    output logic                        done,
    output logic [rlw_pkg::RATIO_W-1:0] quotient
);
    import rlw_pkg::*;

    localparam int STEPS    = FRAC_W / 2;
    localparam int CNT_W    = $clog2(STEPS);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(STEPS - 1);

    logic              active_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;
    logic [SIZE_W-1:0] rem_reg;
    logic [SIZE_W-1:0] rem_next;
    logic [SIZE_W-1:0] div_reg;
    logic [FRAC_W-1:0] frac_reg;
    logic              int_reg;
    logic [1:0]        bits_next;

    // One restoring step: remainder stays below the divisor
    function automatic logic [SIZE_W:0] div_step(input logic [SIZE_W-1:0] rem,
                                                 input logic [SIZE_W-1:0] dv);
        logic [SIZE_W:0] r2;
        logic            bit_q;
        r2    = {rem, 1'b0};
        bit_q = (r2 >= {1'b0, dv});
        if (bit_q)
        begin
            r2 = r2 - {1'b0, dv};
        end
        return {bit_q, r2[SIZE_W-1:0]};
    endfunction

    // Two quotient bits per cycle
    always_comb
    begin
        logic [SIZE_W:0] s1;
        logic [SIZE_W:0] s2;
        s1 = div_step(rem_reg, div_reg);
        s2 = div_step(s1[SIZE_W-1:0], div_reg);
        bits_next = {s1[SIZE_W], s2[SIZE_W]};
        rem_next  = s2[SIZE_W-1:0];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= '0;
            end
            else if (active_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_CNT)
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient; dividend never exceeds divisor
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg  <= divisor;
            int_reg  <= (dividend == divisor);
            rem_reg  <= (dividend == divisor) ? '0 : dividend;
            frac_reg <= '0;
        end
        else if (active_reg)
        begin
            rem_reg  <= rem_next;
            frac_reg <= {frac_reg[FRAC_W-3:0], bits_next};
        end
    end

    assign done     = done_reg;
    assign quotient = {int_reg, frac_reg};

endmodule

@@ hw/rtl/rlw_dp.sv @@
// Datapath: item latch, divider, scale arithmetic, coordinate fold and frame store.
module rlw_dp #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rlw_pkg::in_item_t      request,
    input  rlw_pkg::cfg_t          cfg,
    input  rlw_pkg::dp_cmd_t       cmd,
    output rlw_pkg::dp_status_t    status,
    output rlw_pkg::out_item_t     result
);
    import rlw_pkg::*;

    localparam int DEPTH  = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);

    // Latched item
    in_item_t               item_reg;

    // Offsets from the centre in half pixels
    logic signed [SIZE_W+1:0] dx;
    logic signed [SIZE_W+1:0] dy;
    logic [SIZE_W+1:0]        dx_neg;
    logic [SIZE_W+1:0]        dy_neg;
    logic [ABS_W-1:0]         adx;
    logic [ABS_W-1:0]         ady;
    logic                     oob;
    logic                     bypass;

    // Divider
    logic                     div_done;
    logic [RATIO_W-1:0]       quotient;

    // Arithmetic stages
    logic [RATIO_W-1:0]       rx_reg;
    logic [RATIO_W-1:0]       ry_reg;
    logic [RATIO_W-1:0]       ratio;
    logic [RATIO_W+FRAC_W-1:0] term_prod;
    logic [RATIO_W-1:0]       term_reg;
    logic [RATIO_W-1:0]       term_next;
    logic [SCALE_W-1:0]       scale_reg;
    logic [SCALE_W-1:0]       scale_next;
    logic [ABS_W+SCALE_W-1:0] prod_x;
    logic [ABS_W+SCALE_W-1:0] prod_y;
    logic [MAG_W-1:0]         magx_reg;
    logic [MAG_W-1:0]         magy_reg;
    logic [COORD_W-1:0]       sc_reg;
    logic [COORD_W-1:0]       sr_reg;
    logic [COORD_W-1:0]       sc_next;
    logic [COORD_W-1:0]       sr_next;

    // Frame store
    logic [3*PIX_W-1:0]       mem [DEPTH];
    logic [ADDR_W-1:0]        waddr;
    logic [ADDR_W-1:0]        raddr;
    logic [3*PIX_W-1:0]       rdata_reg;

    // Source coordinate on one axis, truncated toward zero, own coordinate if outside
    function automatic logic [COORD_W-1:0] warp_axis(input logic [MAG_W-1:0]   mag,
                                                     input logic               neg,
                                                     input logic [SIZE_W-1:0]  size,
                                                     input logic [COORD_W-1:0] own);
        logic signed [SIZE_W+2:0] t;
        logic signed [SIZE_W+2:0] v2;
        logic signed [SIZE_W+2:0] c;
        logic signed [SIZE_W+2:0] sz;
        logic [COORD_W-1:0]       res;
        sz = $signed({3'b000, size});
        t  = $signed({3'b000, mag});
        if (neg)
        begin
            t = -t;
        end
        v2 = (t <<< 1) + sz;
        if (v2 < 0)
        begin
            c = -((-v2) >>> 1);
        end
        else
        begin
            c = v2 >>> 1;
        end
        if (c < 0 || c >= sz)
        begin
            res = own;
        end
        else
        begin
            res = c[COORD_W-1:0];
        end
        return res;
    endfunction

    // Item latch
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= request;
        end
    end

    // Range, offsets and pass-through detection
    always_comb
    begin
        dx     = $signed({2'b00, item_reg.column, 1'b0}) - $signed({2'b00, cfg.cols});
        dy     = $signed({2'b00, item_reg.row, 1'b0}) - $signed({2'b00, cfg.rows});
        dx_neg = -dx;
        dy_neg = -dy;
        adx    = dx[SIZE_W+1] ? dx_neg[ABS_W-1:0] : dx[ABS_W-1:0];
        ady    = dy[SIZE_W+1] ? dy_neg[ABS_W-1:0] : dy[ABS_W-1:0];
        oob    = ({1'b0, item_reg.column} >= cfg.cols) || ({1'b0, item_reg.row} >= cfg.rows);
        bypass = (item_reg.column == '0) || (dx == 0 && dy == 0);
    end

    assign status.is_read      = (item_reg.opcode == OP_READ);
    assign status.out_of_image = oob;
    assign status.pass_through = bypass;
    assign status.div_done     = div_done;

    // Shared divider for both axes
    rlw_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (cmd.div_sel_y ? ady : adx),
        .divisor  (cmd.div_sel_y ? cfg.rows : cfg.cols),
        .done     (div_done),
        .quotient (quotient)
    );

    // Ratio, scale and magnitudes
    always_comb
    begin
        ratio      = (rx_reg > ry_reg) ? rx_reg : ry_reg;
        term_prod  = (RATIO_W+FRAC_W)'(ratio) * (RATIO_W+FRAC_W)'(Q_EIGHT_TENTHS);
        term_next  = term_prod[RATIO_W+FRAC_W-1:FRAC_W];
        scale_next = (cfg.mode == MODE_BARREL) ? (Q_EIGHTEEN_TENTHS - term_reg)
                                               : (Q_TWO_TENTHS + term_reg);
        prod_x     = (ABS_W+SCALE_W)'(adx) * (ABS_W+SCALE_W)'(scale_reg);
        prod_y     = (ABS_W+SCALE_W)'(ady) * (ABS_W+SCALE_W)'(scale_reg);
        sc_next    = bypass ? item_reg.column
                            : warp_axis(magx_reg, dx[SIZE_W+1], cfg.cols, item_reg.column);
        sr_next    = bypass ? item_reg.row
                            : warp_axis(magy_reg, dy[SIZE_W+1], cfg.rows, item_reg.row);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_rx)
        begin
            rx_reg <= quotient;
        end
        if (cmd.load_ry)
        begin
            ry_reg <= quotient;
        end
        if (cmd.calc_term)
        begin
            term_reg <= term_next;
        end
        if (cmd.calc_scale)
        begin
            scale_reg <= scale_next;
        end
        if (cmd.calc_mag)
        begin
            magx_reg <= prod_x[ABS_W+SCALE_W-1:SCALE_W];
            magy_reg <= prod_y[ABS_W+SCALE_W-1:SCALE_W];
        end
        if (cmd.calc_coord)
        begin
            sc_reg <= sc_next;
            sr_reg <= sr_next;
        end
    end

    // Frame store: row-major, blue:green:red from high to low
    assign waddr = ADDR_W'(item_reg.row) * ADDR_W'(MAX_COLS) + ADDR_W'(item_reg.column);
    assign raddr = ADDR_W'(sr_reg) * ADDR_W'(MAX_COLS) + ADDR_W'(sc_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.write && !oob)
        begin
            mem[waddr] <= {item_reg.blue_in, item_reg.green_in, item_reg.red_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fetch)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // Result fields; a read outside the image returns all zeros
    always_comb
    begin
        if (oob)
        begin
            result = '0;
        end
        else
        begin
            result.red_out       = rdata_reg[PIX_W-1:0];
            result.green_out     = rdata_reg[2*PIX_W-1:PIX_W];
            result.blue_out      = rdata_reg[3*PIX_W-1:2*PIX_W];
            result.source_column = sc_reg;
            result.source_row    = sr_reg;
        end
    end

endmodule

@@ hw/rtl/rlw_ctrl.sv @@
// Controller state machine sequencing writes, reads and the warp arithmetic.
module rlw_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  rlw_pkg::dp_status_t  status,
    output rlw_pkg::dp_cmd_t     cmd,
    output logic                 busy,
    output logic                 done
);
    import rlw_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_DECODE = 10'b0000000010,
        ST_DIVX   = 10'b0000000100,
        ST_DIVY   = 10'b0000001000,
        ST_TERM   = 10'b0000010000,
        ST_SCALE  = 10'b0000100000,
        ST_MAG    = 10'b0001000000,
        ST_COORD  = 10'b0010000000,
        ST_FETCH  = 10'b0100000000,
        ST_RESP   = 10'b1000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (!status.is_read)
                begin
                    cmd.write  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (status.out_of_image)
                begin
                    state_next = ST_RESP;
                end
                else if (status.pass_through)
                begin
                    state_next = ST_COORD;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVX;
                end
            end
            ST_DIVX:
            begin
                if (status.div_done)
                begin
                    cmd.load_rx   = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel_y = 1'b1;
                    state_next    = ST_DIVY;
                end
            end
            ST_DIVY:
            begin
                if (status.div_done)
                begin
                    cmd.load_ry = 1'b1;
                    state_next  = ST_TERM;
                end
            end
            ST_TERM:
            begin
                cmd.calc_term = 1'b1;
                state_next    = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.calc_scale = 1'b1;
                state_next     = ST_MAG;
            end
            ST_MAG:
            begin
                cmd.calc_mag = 1'b1;
                state_next   = ST_COORD;
            end
            ST_COORD:
            begin
                cmd.calc_coord = 1'b1;
                state_next     = ST_FETCH;
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_RESP);

endmodule

@@ hw/rtl/radial_lens_warp_engine_top.sv @@
// Top level of the radial lens warp engine: register port, controller and datapath.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+----------------------------
//  request  | in        | start & !busy             | in_item_t (opcode, pixel)
//  result   | out       | done, one cycle, no stall | out_item_t (pixel, source)
//  config   | in        | APB psel/penable/pwrite   | image_cols, image_rows, mode
//
//  A write holds busy for one cycle after its transfer. A read outside the image
//  goes from decode straight to the result state; column zero and the centre pixel
//  skip the divider and go through fold, store read and result. A warped read
//  makes two passes of the shared divider at two quotient bits per cycle, then
//  term, scale, multiply, fold, store read and result. Reset is asynchronous and
//  active low and resets the controller and config registers, not the frame store.
module radial_lens_warp_engine_top #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  rlw_pkg::in_item_t  request,
    output logic               done,
    output rlw_pkg::out_item_t result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import rlw_pkg::*;

    logic [SIZE_W-1:0] cols_reg;
    logic [SIZE_W-1:0] rows_reg;
    logic              mode_reg;
    logic              cfg_write;
    cfg_t              cfg;
    dp_cmd_t           cmd;
    dp_status_t        status;

    // Register writes
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= 7'd64;
            rows_reg <= 7'd64;
            mode_reg <= MODE_FISHEYE;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_COLS: cols_reg <= pwdata[SIZE_W-1:0];
                REG_ROWS: rows_reg <= pwdata[SIZE_W-1:0];
                REG_MODE: mode_reg <= pwdata[0];
                default:  ;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        case (paddr[3:2])
            REG_COLS: prdata = {25'd0, cols_reg};
            REG_ROWS: prdata = {25'd0, rows_reg};
            REG_MODE: prdata = {31'd0, mode_reg};
            default:  prdata = '0;
        endcase
    end

    // Sizes in use: zero counts as one, above the store counts as its maximum
    always_comb
    begin
        if (cols_reg == '0)
        begin
            cfg.cols = SIZE_W'(1);
        end
        else if (32'(cols_reg) > MAX_COLS)
        begin
            cfg.cols = SIZE_W'(MAX_COLS);
        end
        else
        begin
            cfg.cols = cols_reg;
        end
        if (rows_reg == '0)
        begin
            cfg.rows = SIZE_W'(1);
        end
        else if (32'(rows_reg) > MAX_ROWS)
        begin
            cfg.rows = SIZE_W'(MAX_ROWS);
        end
        else
        begin
            cfg.rows = rows_reg;
        end
        cfg.mode = mode_reg;
    end

    rlw_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    rlw_dp #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cfg     (cfg),
        .cmd     (cmd),
        .status  (status),
        .result  (result)
    );

endmodule

@@ hw/rtl/rlw_checker.sv @@
// Port-level checker for the radial lens warp engine, bound to the top level.
`include "assert_macros.svh"

module rlw_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // A result strobe only appears while an item is in flight
    `RLW_ASSERT(a_done_while_busy, clk, rst_n, !done || busy)

    // An accepted transfer keeps the engine busy in the following cycle
    `RLW_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)

    // The result strobe lasts exactly one cycle
    `RLW_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)

    // After a result the engine is ready again
    `RLW_ASSERT_NEXT(a_done_then_idle, clk, rst_n, done, !busy)

endmodule

bind radial_lens_warp_engine_top rlw_checker u_rlw_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
